// ----- hw/rtl/tceu_pkg.sv -----
// ----------------------------------------------------------------------------
// tceu_pkg
// Types and constants shared by the execute unit's front, back and queues.
// ----------------------------------------------------------------------------
package tceu_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned FIELD_W     = 5;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// instruction word layout
	localparam int unsigned CLASS_BIT   = 31;  // clear: two-address ALU op
	localparam int unsigned IO_BIT      = 30;  // clear: jump
	localparam int unsigned INOUT_BIT   = 29;  // clear: halt
	localparam int unsigned OUT_SEL_BIT = 7;   // set: OUT, clear: IN
	localparam int unsigned SRC_REG_BIT = 10;  // set: register source
	localparam int unsigned OP_MSB      = 15;
	localparam int unsigned OP_LSB      = 12;
	localparam int unsigned SRC_MSB     = 9;
	localparam int unsigned SRC_LSB     = 5;
	localparam int unsigned DST_MSB     = 4;
	localparam int unsigned DST_LSB     = 0;
	localparam int unsigned IN_DST_MSB  = 6;
	localparam int unsigned IN_DST_LSB  = 2;
	localparam int unsigned JSEL_MSB    = 6;
	localparam int unsigned JSEL_LSB    = 5;

	// flag word bits
	localparam int unsigned FLAG_SIGN_BIT = 7;
	localparam int unsigned FLAG_ZERO_BIT = 1;

	typedef enum logic [3:0] {
		OP_MOV = 4'd0,
		OP_ADD = 4'd3,
		OP_SUB = 4'd4,
		OP_XOR = 4'd5,
		OP_AND = 4'd6,
		OP_OR  = 4'd7,
		OP_CMP = 4'd8,
		OP_NOT = 4'd9
	} alu_op_t;

	typedef enum logic [1:0] {
		JS_JMP = 2'd0,
		JS_JEQ = 2'd1,
		JS_JNE = 2'd2
	} jump_sel_t;

	typedef enum logic [2:0] {
		KIND_ALU     = 3'd0,
		KIND_CMP     = 3'd1,
		KIND_IN      = 3'd2,
		KIND_OUT     = 3'd3,
		KIND_JUMP    = 3'd4,
		KIND_HALT    = 3'd5,
		KIND_IGNORED = 3'd6
	} kind_t;

	// classified instruction, front to back
	typedef struct packed {
		kind_t               kind;
		alu_op_t             op;
		jump_sel_t           jsel;
		logic                src_is_reg;
		logic [FIELD_W-1:0]  src_addr;   // also the immediate
		logic [FIELD_W-1:0]  dst_addr;   // also the jump label
		logic [WORD_W-1:0]   in_value;
	} dec_t;

	// one result beat
	typedef struct packed {
		kind_t               kind;
		logic [WORD_W-1:0]   value;
		logic [FIELD_W-1:0]  dest_reg;
		logic                taken;
		logic [FIELD_W-1:0]  label;
		logic                sign;
		logic                zero;
		logic                equal;
	} res_t;

endpackage

// ----- hw/rtl/toy_cpu_execute_unit_top.sv -----
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit_top
// Execute unit of a small two-address machine with a 32-entry register file.
//
// Input channel: an instruction beat (instr_word, in_value) is taken on a
//   rising edge with push high and full low.
// Result channel: while empty is low the oldest result sits on kind, value,
//   dest_reg, branch_taken, branch_label and the three flags; it is taken on a
//   rising edge with pop high.
// Exactly one result beat comes out per instruction beat, in order.
// Path: a pushed beat is written into the decode queue, read from the register
//   file into the execute-stage registers, then pushed into the result queue.
// Throughput: one instruction per cycle while the result queue has room; the
//   register-file write-back is forwarded to the next instruction's read.
// Stalls: when the result queue fills, the execute stage holds, the decode
//   queue fills behind it and full rises; nothing is lost or repeated.
// Reset: registers read as zero (per-entry valid bits), the compare flag and
//   the halt state clear, both queues empty. No clearing pass is needed.
// After a halt instruction every beat returns a halt result until reset.
// ----------------------------------------------------------------------------
module toy_cpu_execute_unit_top #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned REG_COUNT  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// instruction side
	input  logic        push,
	output logic        full,
	input  logic [31:0] instr_word,
	input  logic signed [31:0] in_value,
	// result side
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic signed [31:0] value,
	output logic [4:0]  dest_reg,
	output logic        branch_taken,
	output logic [4:0]  branch_label,
	output logic        sign_flag,
	output logic        zero_flag,
	output logic        equal_flag
);

	localparam int unsigned DEC_W = $bits(tceu_pkg::dec_t);
	localparam int unsigned RES_W = $bits(tceu_pkg::res_t);

	tceu_pkg::dec_t    dec;
	logic [DEC_W-1:0]  dq_dout;
	logic              dq_empty;
	logic              dq_pop;

	logic              rq_full;
	logic              rq_push;
	tceu_pkg::res_t    rq_din;
	logic [RES_W-1:0]  rq_dout;
	tceu_pkg::res_t    res;

	// front: classify the word
	tceu_decode u_decode (
		.instr_word (instr_word),
		.in_value   (in_value),
		.dec        (dec)
	);

	// short queue between front and back
	tceu_fifo #(
		.WIDTH (DEC_W)
	) u_dec_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (dec),
		.full   (full),
		.pop    (dq_pop),
		.dout   (dq_dout),
		.empty  (dq_empty)
	);

	// back: register file, ALU, write-back
	tceu_exec #(
		.DATA_WIDTH (DATA_WIDTH),
		.REG_COUNT  (REG_COUNT)
	) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.dq_empty (dq_empty),
		.dq_data  (tceu_pkg::dec_t'(dq_dout)),
		.dq_pop   (dq_pop),
		.rq_full  (rq_full),
		.rq_push  (rq_push),
		.rq_data  (rq_din)
	);

	// result queue decouples execute from the receiver
	tceu_fifo #(
		.WIDTH (RES_W)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.din    (rq_din),
		.full   (rq_full),
		.pop    (pop),
		.dout   (rq_dout),
		.empty  (empty)
	);

	assign res          = tceu_pkg::res_t'(rq_dout);
	assign kind         = res.kind;
	assign value        = res.value;
	assign dest_reg     = res.dest_reg;
	assign branch_taken = res.taken;
	assign branch_label = res.label;
	assign sign_flag    = res.sign;
	assign zero_flag    = res.zero;
	assign equal_flag   = res.equal;

endmodule

// ----- hw/rtl/tceu_fifo.sv -----
// ----------------------------------------------------------------------------
// tceu_fifo
// Small register queue with full/empty flags, used between the stages.
// ----------------------------------------------------------------------------
module tceu_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0]              slot_q [tceu_pkg::QUEUE_DEPTH];
	logic [tceu_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [tceu_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [tceu_pkg::QCNT_W-1:0]   cnt_q;
	logic                          do_push;
	logic                          do_pop;

	assign full    = (cnt_q == tceu_pkg::QCNT_W'(tceu_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == tceu_pkg::QPTR_W'(tceu_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == tceu_pkg::QPTR_W'(tceu_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/tceu_decode.sv -----
// ----------------------------------------------------------------------------
// tceu_decode
// Front end: classifies an instruction word and extracts its fields.
// ----------------------------------------------------------------------------
module tceu_decode (
	input  logic [tceu_pkg::WORD_W-1:0] instr_word,
	input  logic [tceu_pkg::WORD_W-1:0] in_value,
	output tceu_pkg::dec_t              dec
);

	always_comb begin
		dec            = '0;
		dec.kind       = tceu_pkg::KIND_IGNORED;
		dec.op         = tceu_pkg::OP_MOV;
		dec.jsel       = tceu_pkg::JS_JMP;
		dec.src_is_reg = instr_word[tceu_pkg::SRC_REG_BIT];
		dec.src_addr   = instr_word[tceu_pkg::SRC_MSB:tceu_pkg::SRC_LSB];
		dec.dst_addr   = instr_word[tceu_pkg::DST_MSB:tceu_pkg::DST_LSB];
		dec.in_value   = in_value;

		if (!instr_word[tceu_pkg::CLASS_BIT]) begin
			unique case (instr_word[tceu_pkg::OP_MSB:tceu_pkg::OP_LSB]) inside
				tceu_pkg::OP_MOV, tceu_pkg::OP_ADD, tceu_pkg::OP_SUB,
				tceu_pkg::OP_XOR, tceu_pkg::OP_AND, tceu_pkg::OP_OR,
				tceu_pkg::OP_NOT: begin
					dec.kind = tceu_pkg::KIND_ALU;
					dec.op   = tceu_pkg::alu_op_t'(
						instr_word[tceu_pkg::OP_MSB:tceu_pkg::OP_LSB]);
				end
				tceu_pkg::OP_CMP: begin
					dec.kind = tceu_pkg::KIND_CMP;
					dec.op   = tceu_pkg::OP_CMP;
				end
				default: begin
					dec.kind = tceu_pkg::KIND_IGNORED;
				end
			endcase
		end else if (!instr_word[tceu_pkg::IO_BIT]) begin
			unique case (instr_word[tceu_pkg::JSEL_MSB:tceu_pkg::JSEL_LSB]) inside
				tceu_pkg::JS_JMP, tceu_pkg::JS_JEQ, tceu_pkg::JS_JNE: begin
					dec.kind = tceu_pkg::KIND_JUMP;
					dec.jsel = tceu_pkg::jump_sel_t'(
						instr_word[tceu_pkg::JSEL_MSB:tceu_pkg::JSEL_LSB]);
				end
				default: begin
					dec.kind = tceu_pkg::KIND_IGNORED;
				end
			endcase
		end else if (instr_word[tceu_pkg::INOUT_BIT]) begin
			if (!instr_word[tceu_pkg::OUT_SEL_BIT]) begin
				dec.kind     = tceu_pkg::KIND_IN;
				dec.dst_addr = instr_word[tceu_pkg::IN_DST_MSB:tceu_pkg::IN_DST_LSB];
			end else begin
				dec.kind = tceu_pkg::KIND_OUT;
			end
		end else begin
			dec.kind = tceu_pkg::KIND_HALT;
		end
	end

endmodule

// ----- hw/rtl/tceu_exec.sv -----
// ----------------------------------------------------------------------------
// tceu_exec
// Back end: register file read, ALU and write-back, with write forwarding.
// ----------------------------------------------------------------------------
module tceu_exec #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned REG_COUNT  = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           dq_empty,
	input  tceu_pkg::dec_t dq_data,
	output logic           dq_pop,
	input  logic           rq_full,
	output logic           rq_push,
	output tceu_pkg::res_t rq_data
);

	localparam int unsigned REG_AW = $clog2(REG_COUNT);
	localparam logic [REG_AW-1:0] FLAG_ADDR = REG_AW'(REG_COUNT - 1);

	// register file; the flag word is never stored, it reads as zero
	logic [DATA_WIDTH-1:0] rf_q [REG_COUNT];
	logic [REG_COUNT-1:0]  rf_vld_q;

	// execute stage
	logic                  x_vld_q;
	tceu_pkg::dec_t        x_dec_s1;
	logic [DATA_WIDTH-1:0] src_mem_s1;
	logic [DATA_WIDTH-1:0] dst_mem_s1;
	logic [DATA_WIDTH-1:0] fwd_data_s1;
	logic                  src_vld_s1;
	logic                  dst_vld_s1;
	logic                  fwd_src_s1;
	logic                  fwd_dst_s1;

	logic                  eq_q;
	logic                  halted_q;

	logic                  take;
	logic                  x_fire;
	logic [REG_AW-1:0]     rd_src;
	logic [REG_AW-1:0]     rd_dst;
	logic                  wr_en;
	logic [REG_AW-1:0]     wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic                  eq_we;
	logic                  eq_next;
	logic                  halt_set;

	logic [DATA_WIDTH-1:0] src_val;
	logic [DATA_WIDTH-1:0] dst_val;
	logic [DATA_WIDTH-1:0] src_op;
	logic [DATA_WIDTH-1:0] alu_r;
	logic [DATA_WIDTH-1:0] in_val;
	logic [63:0]           in_ext;
	logic [DATA_WIDTH-1:0] out_v;
	logic [63:0]           out_wide;
	logic [DATA_WIDTH-1:0] flag_v;
	logic                  flag_en;
	logic                  flag_to_reg;
	logic                  dst_is_flag;
	tceu_pkg::res_t        res;

	assign x_fire  = x_vld_q && !rq_full;
	assign take    = !dq_empty && (!x_vld_q || x_fire);
	assign dq_pop  = take;
	assign rd_src  = REG_AW'(dq_data.src_addr);
	assign rd_dst  = REG_AW'(dq_data.dst_addr);
	assign rq_push = x_fire;
	assign rq_data = res;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rf_q[wr_addr] <= wr_data;
		end
		if (take) begin
			src_mem_s1  <= rf_q[rd_src];
			dst_mem_s1  <= rf_q[rd_dst];
			fwd_data_s1 <= wr_data;
			x_dec_s1    <= dq_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q   <= '0;
			x_vld_q    <= 1'b0;
			src_vld_s1 <= 1'b0;
			dst_vld_s1 <= 1'b0;
			fwd_src_s1 <= 1'b0;
			fwd_dst_s1 <= 1'b0;
			eq_q       <= 1'b0;
			halted_q   <= 1'b0;
		end else begin
			if (take) begin
				x_vld_q    <= 1'b1;
				src_vld_s1 <= rf_vld_q[rd_src];
				dst_vld_s1 <= rf_vld_q[rd_dst];
				// the beat leaving execute writes at this same edge
				fwd_src_s1 <= wr_en && (wr_addr == rd_src);
				fwd_dst_s1 <= wr_en && (wr_addr == rd_dst);
			end else if (x_fire) begin
				x_vld_q <= 1'b0;
			end
			if (wr_en) begin
				rf_vld_q[wr_addr] <= 1'b1;
			end
			if (eq_we) begin
				eq_q <= eq_next;
			end
			if (halt_set) begin
				halted_q <= 1'b1;
			end
		end
	end

	always_comb begin
		src_val = fwd_src_s1 ? fwd_data_s1 : (src_vld_s1 ? src_mem_s1 : '0);
		dst_val = fwd_dst_s1 ? fwd_data_s1 : (dst_vld_s1 ? dst_mem_s1 : '0);
		src_op  = x_dec_s1.src_is_reg ? src_val : DATA_WIDTH'(x_dec_s1.src_addr);
		in_ext  = 64'(signed'(x_dec_s1.in_value));
		in_val  = in_ext[DATA_WIDTH-1:0];
		eq_next = (src_op == dst_val);
		dst_is_flag = (REG_AW'(x_dec_s1.dst_addr) == FLAG_ADDR);

		case (x_dec_s1.op)
			tceu_pkg::OP_MOV: alu_r = src_op;
			tceu_pkg::OP_ADD: alu_r = dst_val + src_op;
			tceu_pkg::OP_SUB: alu_r = dst_val - src_op;
			tceu_pkg::OP_XOR: alu_r = dst_val ^ src_op;
			tceu_pkg::OP_AND: alu_r = dst_val & src_op;
			tceu_pkg::OP_OR:  alu_r = dst_val | src_op;
			tceu_pkg::OP_NOT: alu_r = ~src_op;
			default:          alu_r = dst_val;
		endcase

		res         = '0;
		res.kind    = x_dec_s1.kind;
		res.equal   = eq_q;
		out_v       = '0;
		flag_v      = '0;
		flag_en     = 1'b0;
		flag_to_reg = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = REG_AW'(x_dec_s1.dst_addr);
		wr_data     = alu_r;
		eq_we       = 1'b0;
		halt_set    = 1'b0;

		unique case (x_dec_s1.kind)
			tceu_pkg::KIND_ALU: begin
				out_v        = alu_r;
				res.dest_reg = x_dec_s1.dst_addr;
				flag_v       = alu_r;
				flag_en      = 1'b1;
				flag_to_reg  = dst_is_flag;
				wr_en        = x_fire && !dst_is_flag;
			end
			tceu_pkg::KIND_CMP: begin
				out_v        = dst_val;
				res.dest_reg = x_dec_s1.dst_addr;
				res.equal    = eq_next;
				flag_v       = dst_val;
				flag_en      = 1'b1;
				eq_we        = x_fire;
			end
			tceu_pkg::KIND_IN: begin
				out_v        = in_val;
				res.dest_reg = x_dec_s1.dst_addr;
				flag_v       = in_val;
				flag_en      = 1'b1;
				flag_to_reg  = dst_is_flag;
				wr_data      = in_val;
				wr_en        = x_fire && !dst_is_flag;
			end
			tceu_pkg::KIND_OUT: begin
				out_v        = dst_val;
				res.dest_reg = x_dec_s1.dst_addr;
				flag_v       = dst_val;
				flag_en      = 1'b1;
			end
			tceu_pkg::KIND_JUMP: begin
				res.label = x_dec_s1.dst_addr;
				case (x_dec_s1.jsel)
					tceu_pkg::JS_JEQ: res.taken = eq_q;
					tceu_pkg::JS_JNE: res.taken = !eq_q;
					default:          res.taken = 1'b1;
				endcase
			end
			tceu_pkg::KIND_HALT: begin
				halt_set = x_fire;
			end
			default: begin
			end
		endcase

		out_wide  = 64'(out_v);
		res.value = out_wide[tceu_pkg::WORD_W-1:0];
		// a result written to the flag word keeps its own bits under the flags
		res.sign  = flag_en && (flag_v[DATA_WIDTH-1] ||
			(flag_to_reg && flag_v[tceu_pkg::FLAG_SIGN_BIT]));
		res.zero  = flag_en && ((flag_v == '0) ||
			(flag_to_reg && flag_v[tceu_pkg::FLAG_ZERO_BIT]));

		if (halted_q) begin
			res      = '0;
			res.kind = tceu_pkg::KIND_HALT;
			wr_en    = 1'b0;
			eq_we    = 1'b0;
			halt_set = 1'b0;
		end
	end

endmodule

// ----- test/toy_cpu_execute_unit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit_checker
// Watches both queue channels of the execute unit, runs its own copy of the
// register file, compare flag and halt state on every accepted instruction
// beat, and compares each popped result beat field by field.
// ----------------------------------------------------------------------------
module toy_cpu_execute_unit_checker #(
	parameter logic [4:0] FLAG_REG = 5'd31
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [31:0]        instr_word,
	input  logic signed [31:0] in_value,
	input  logic               empty,
	input  logic               pop,
	input  logic [2:0]         kind,
	input  logic signed [31:0] value,
	input  logic [4:0]         dest_reg,
	input  logic               branch_taken,
	input  logic [4:0]         branch_label,
	input  logic               sign_flag,
	input  logic               zero_flag,
	input  logic               equal_flag,
	output int                 fail_count,
	output int                 due_count
);
	import tceu_pkg::*;

	localparam int MAX_REPORTS = 10;

	logic [WORD_W-1:0] arch_regs [32];
	logic              cmp_equal;
	logic              halted_st;
	res_t              results_due [$];
	int                mismatches = 0;

	// architectural effect of one instruction and the result beat it yields
	function automatic res_t exec_instr(input logic [31:0] w, input logic [31:0] inv);
		res_t              r;
		logic [WORD_W-1:0] src;
		logic [WORD_W-1:0] dst;
		logic [WORD_W-1:0] rv;
		logic [WORD_W-1:0] fv;
		logic [4:0]        d;
		logic [4:0]        s;
		logic [4:0]        ir;
		logic              touched;
		r      = '0;
		r.kind = KIND_IGNORED;
		d      = w[DST_MSB:DST_LSB];
		s      = w[SRC_MSB:SRC_LSB];
		rv     = '0;
		fv     = '0;
		if (halted_st) begin
			r.kind = KIND_HALT;
			return r;
		end
		arch_regs[FLAG_REG] = '0;
		touched = 1'b0;
		if (!w[CLASS_BIT]) begin
			src = w[SRC_REG_BIT] ? arch_regs[s] : {{(WORD_W-FIELD_W){1'b0}}, s};
			dst = arch_regs[d];
			touched = 1'b1;
			case (w[OP_MSB:OP_LSB])
				OP_MOV: rv = src;
				OP_ADD: rv = dst + src;
				OP_SUB: rv = dst - src;
				OP_XOR: rv = dst ^ src;
				OP_AND: rv = dst & src;
				OP_OR:  rv = dst | src;
				OP_NOT: rv = ~src;
				OP_CMP: rv = dst;
				default: touched = 1'b0;
			endcase
			if (touched) begin
				r.value    = rv;
				r.dest_reg = d;
				fv         = rv;
				if (w[OP_MSB:OP_LSB] == OP_CMP) begin
					cmp_equal = (src == dst);
					r.kind    = KIND_CMP;
				end else begin
					arch_regs[d] = rv;
					r.kind       = KIND_ALU;
				end
			end
		end else if (!w[IO_BIT]) begin
			case (w[JSEL_MSB:JSEL_LSB])
				JS_JMP: begin
					r.kind  = KIND_JUMP;
					r.label = d;
					r.taken = 1'b1;
				end
				JS_JEQ: begin
					r.kind  = KIND_JUMP;
					r.label = d;
					r.taken = cmp_equal;
				end
				JS_JNE: begin
					r.kind  = KIND_JUMP;
					r.label = d;
					r.taken = !cmp_equal;
				end
				default: ;
			endcase
		end else if (w[INOUT_BIT]) begin
			if (!w[OUT_SEL_BIT]) begin
				ir            = w[IN_DST_MSB:IN_DST_LSB];
				arch_regs[ir] = inv;
				r.kind        = KIND_IN;
				r.dest_reg    = ir;
			end else begin
				r.kind     = KIND_OUT;
				r.dest_reg = d;
			end
			r.value = arch_regs[r.dest_reg];
			fv      = r.value;
			touched = 1'b1;
		end else begin
			halted_st = 1'b1;
			r.kind    = KIND_HALT;
		end
		// flags are ORed over whatever now sits in the flag word
		if (touched) begin
			if (fv[WORD_W-1])
				arch_regs[FLAG_REG][FLAG_SIGN_BIT] = 1'b1;
			if (fv == '0)
				arch_regs[FLAG_REG][FLAG_ZERO_BIT] = 1'b1;
		end
		r.sign  = arch_regs[FLAG_REG][FLAG_SIGN_BIT];
		r.zero  = arch_regs[FLAG_REG][FLAG_ZERO_BIT];
		r.equal = cmp_equal;
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < 32; i++)
				arch_regs[i] = '0;
			cmp_equal = 1'b0;
			halted_st = 1'b0;
			results_due.delete();
		end else begin
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result beat with nothing expected, kind %0d value %h",
							$time, kind, value);
				end else begin
					want = results_due.pop_front();
					check_field("kind",         32'(want.kind),     32'(kind));
					check_field("value",        want.value,         value);
					check_field("dest_reg",     32'(want.dest_reg), 32'(dest_reg));
					check_field("branch_taken", 32'(want.taken),    32'(branch_taken));
					check_field("branch_label", 32'(want.label),    32'(branch_label));
					check_field("sign_flag",    32'(want.sign),     32'(sign_flag));
					check_field("zero_flag",    32'(want.zero),     32'(zero_flag));
					check_field("equal_flag",   32'(want.equal),    32'(equal_flag));
				end
			end
			if (push && !full)
				results_due.push_back(exec_instr(instr_word, in_value));
		end
		due_count  <= results_due.size();
		fail_count <= mismatches;
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for toy_cpu_execute_unit_top: a directed run over every opcode and
// corner, then constrained-by-hand random instruction streams under several
// push/pop idling mixes, closed by a halt and a few words that must bounce.
// ----------------------------------------------------------------------------
module tb;
	import tceu_pkg::*;

	localparam logic [4:0] FLAG_REG      = 5'd31;
	localparam logic [1:0] JS_NONE       = 2'd3;   // jump selector with no meaning
	localparam logic [3:0] OP_RSVD_LO    = 4'd1;   // reserved ALU codes 1..2
	localparam logic [3:0] OP_RSVD_MID   = 4'd2;
	localparam logic [3:0] OP_RSVD_FIRST = 4'd10;  // reserved ALU codes 10..15
	localparam logic [3:0] OP_RSVD_LAST  = 4'd15;
	localparam alu_op_t    WRITE_OPS [7] = '{OP_MOV, OP_ADD, OP_SUB, OP_XOR,
		OP_AND, OP_OR, OP_NOT};
	localparam int PHASE_ITEMS  = 138;
	localparam int DRAIN_CYCLES = 10;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               push       = 1'b0;
	logic               pop        = 1'b0;
	logic [31:0]        instr_word = '0;
	logic signed [31:0] in_value   = '0;
	logic               full;
	logic               empty;
	logic [2:0]         kind;
	logic signed [31:0] value;
	logic [4:0]         dest_reg;
	logic               branch_taken;
	logic [4:0]         branch_label;
	logic               sign_flag;
	logic               zero_flag;
	logic               equal_flag;
	int                 fail_count;
	int                 due_count;

	// idling mix, percent of cycles; changed per phase by the stimulus
	int send_idle_pct = 0;
	int pop_stall_pct = 0;

	always #10 clk = ~clk;

	toy_cpu_execute_unit_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.instr_word   (instr_word),
		.in_value     (in_value),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.value        (value),
		.dest_reg     (dest_reg),
		.branch_taken (branch_taken),
		.branch_label (branch_label),
		.sign_flag    (sign_flag),
		.zero_flag    (zero_flag),
		.equal_flag   (equal_flag)
	);

	toy_cpu_execute_unit_checker #(.FLAG_REG(FLAG_REG)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.instr_word   (instr_word),
		.in_value     (in_value),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.value        (value),
		.dest_reg     (dest_reg),
		.branch_taken (branch_taken),
		.branch_label (branch_label),
		.sign_flag    (sign_flag),
		.zero_flag    (zero_flag),
		.equal_flag   (equal_flag),
		.fail_count   (fail_count),
		.due_count    (due_count)
	);

	// result side: pop is re-rolled every cycle against the current stall mix
	always @(posedge clk) begin
		if (!arst_n)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	// --- instruction word builders; don't-care bits are left random so that
	// every bit of the word toggles over the run
	function automatic logic [31:0] alu_word(input logic [3:0] op, input logic src_reg,
			input logic [4:0] src, input logic [4:0] dst);
		logic [31:0] w;
		w                  = $urandom;
		w[CLASS_BIT]       = 1'b0;
		w[OP_MSB:OP_LSB]   = op;
		w[SRC_REG_BIT]     = src_reg;
		w[SRC_MSB:SRC_LSB] = src;
		w[DST_MSB:DST_LSB] = dst;
		return w;
	endfunction

	function automatic logic [31:0] jump_word(input logic [1:0] sel, input logic [4:0] label);
		logic [31:0] w;
		w                    = $urandom;
		w[CLASS_BIT]         = 1'b1;
		w[IO_BIT]            = 1'b0;
		w[JSEL_MSB:JSEL_LSB] = sel;
		w[DST_MSB:DST_LSB]   = label;
		return w;
	endfunction

	function automatic logic [31:0] io_word(input logic is_out, input logic [4:0] r);
		logic [31:0] w;
		w              = $urandom;
		w[CLASS_BIT]   = 1'b1;
		w[IO_BIT]      = 1'b1;
		w[INOUT_BIT]   = 1'b1;
		w[OUT_SEL_BIT] = is_out;
		if (is_out)
			w[DST_MSB:DST_LSB] = r;
		else
			w[IN_DST_MSB:IN_DST_LSB] = r;
		return w;
	endfunction

	// mostly a small working set so results feed later instructions
	function automatic logic [4:0] pick_reg();
		if ($urandom_range(99) < 80)
			return 5'($urandom_range(7));
		return 5'($urandom_range(31));
	endfunction

	// one instruction beat: optional idle cycles, then hold push until taken.
	// full is read right after the edge, i.e. the value the edge saw.
	task automatic send_instr(input logic [31:0] w, input logic [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push       <= 1'b1;
		instr_word <= w;
		in_value   <= v;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// hard stop in case the block wedges
	initial begin
		#5_000_000;
		$display("** toy_cpu_execute_unit_top: FAILED **");
		$finish;
	end

	initial begin
		logic [31:0] w;
		logic [31:0] v;
		logic [4:0]  dst;
		logic [4:0]  src;
		logic        src_reg;
		int          pick;
		int          useful;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed: extremes, every op, flag-word and compare corners,
		// back to back with no idling
		send_instr(io_word(1'b0, 5'd1), 32'h7fff_ffff);     // IN max positive
		send_instr(io_word(1'b0, 5'd2), 32'h8000_0000);     // IN most negative
		send_instr(io_word(1'b0, 5'd3), 32'hffff_ffff);     // IN -1
		send_instr(io_word(1'b0, FLAG_REG), 32'h1234_5678); // IN into flag word
		send_instr(alu_word(OP_ADD, 1'b1, 5'd1, 5'd1), $urandom);   // wraps to negative
		send_instr(alu_word(OP_SUB, 1'b0, 5'd1, 5'd2), $urandom);   // wraps to positive
		send_instr(alu_word(OP_MOV, 1'b0, 5'd31, 5'd4), $urandom);  // largest immediate
		send_instr(alu_word(OP_XOR, 1'b1, 5'd4, 5'd4), $urandom);   // self xor -> zero
		send_instr(alu_word(OP_AND, 1'b1, 5'd1, 5'd3), $urandom);
		send_instr(alu_word(OP_OR,  1'b0, 5'd0, 5'd5), $urandom);   // zero immediate
		send_instr(alu_word(OP_NOT, 1'b1, FLAG_REG, 5'd6), $urandom); // flag word reads 0
		send_instr(alu_word(OP_MOV, 1'b1, 5'd3, FLAG_REG), $urandom); // write flag word
		send_instr(alu_word(OP_CMP, 1'b1, 5'd1, 5'd1), $urandom);   // equal
		send_instr(jump_word(JS_JEQ, 5'd31), $urandom);
		send_instr(jump_word(JS_JNE, 5'd0), $urandom);
		send_instr(alu_word(OP_CMP, 1'b0, 5'd5, 5'd4), $urandom);   // not equal
		send_instr(jump_word(JS_JEQ, 5'd9), $urandom);
		send_instr(jump_word(JS_JNE, 5'd18), $urandom);
		send_instr(jump_word(JS_JMP, 5'd21), $urandom);
		send_instr(jump_word(JS_NONE, 5'd7), $urandom);             // selector with no jump
		send_instr(alu_word(OP_RSVD_LO, 1'b1, 5'd1, 5'd2), $urandom);  // reserved ALU codes
		send_instr(alu_word(OP_RSVD_LAST, 1'b0, 5'd3, 5'd1), $urandom);
		send_instr(io_word(1'b1, 5'd2), $urandom);                  // OUT
		send_instr(io_word(1'b1, FLAG_REG), $urandom);              // OUT of cleared flag word
		send_instr(alu_word(OP_CMP, 1'b1, FLAG_REG, FLAG_REG), $urandom);

		// ---- random streams, one phase per idling mix: none, sender-heavy,
		// receiver-heavy, then light on both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
				1: begin send_idle_pct = 74; pop_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  pop_stall_pct = 74; end
				default: begin send_idle_pct = 11; pop_stall_pct = 11; end
			endcase
			useful = 0;
			while (useful < PHASE_ITEMS) begin
				pick    = $urandom_range(99);
				dst     = pick_reg();
				src_reg = 1'($urandom_range(1));
				// a register source equal to dst zeroes SUB and XOR and makes compares equal
				src     = ($urandom_range(3) == 0) ? dst :
					(src_reg ? pick_reg() : 5'($urandom_range(31)));
				v       = $urandom;
				useful++;
				if (pick < 45) begin
					w = alu_word(WRITE_OPS[$urandom_range(6)], src_reg, src, dst);
				end else if (pick < 57) begin
					w = alu_word(OP_CMP, src_reg, src, dst);
				end else if (pick < 69) begin
					w = jump_word(2'($urandom_range(2)), 5'($urandom_range(31)));
				end else if (pick < 79) begin
					w = io_word(1'b0, dst);
					case ($urandom_range(4))
						0: v = 32'h8000_0000;
						1: v = 32'h7fff_ffff;
						2: v = '0;
						3: v = $urandom_range(15);
						default: v = $urandom;
					endcase
				end else if (pick < 89) begin
					w = io_word(1'b1, dst);
				end else begin
					// noise: reserved codes, dead jump selector, raw words.
					// a raw word must never halt the machine mid-run.
					useful--;
					case ($urandom_range(2))
						0: w = alu_word($urandom_range(1) ?
							4'($urandom_range(OP_RSVD_MID, OP_RSVD_LO)) :
							4'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST)),
							src_reg, src, dst);
						1: w = jump_word(JS_NONE, dst);
						default: begin
							w = $urandom;
							if (w[CLASS_BIT] && w[IO_BIT] && !w[INOUT_BIT])
								w[INOUT_BIT] = 1'b1;
						end
					endcase
				end
				send_instr(w, v);
			end
		end

		// ---- halt, then every later word must come back as a bare halt beat
		w            = $urandom;
		w[CLASS_BIT] = 1'b1;
		w[IO_BIT]    = 1'b1;
		w[INOUT_BIT] = 1'b0;
		send_instr(w, $urandom);
		send_instr(alu_word(OP_ADD, 1'b0, 5'd1, 5'd1), $urandom);
		send_instr(io_word(1'b0, 5'd3), 32'h8000_0000);
		send_instr(io_word(1'b1, 5'd3), $urandom);
		send_instr(jump_word(JS_JMP, 5'd5), $urandom);
		send_instr(alu_word(OP_CMP, 1'b1, 5'd0, 5'd0), $urandom);

		// drain: wait for every expected beat, then a few cycles for strays
		push <= 1'b0;
		do
			@(posedge clk);
		while (due_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("** toy_cpu_execute_unit_top: PASSED **");
		else
			$display("** toy_cpu_execute_unit_top: FAILED **");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/tceu_pkg.sv
hw/rtl/tceu_fifo.sv
hw/rtl/tceu_decode.sv
hw/rtl/tceu_exec.sv
hw/rtl/toy_cpu_execute_unit_top.sv
test/toy_cpu_execute_unit_checker.sv
test/tb.sv
